@@ rtl/core/rsame_pkg.sv @@
`default_nettype none
package rsame_pkg;

   localparam int WORD_BITS_DEF = 32;
   localparam int FIELD_BITS    = 32;
   localparam int CSR_IDX_BITS  = 2;

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   localparam logic [CSR_IDX_BITS-1:0] REG_MODULUS     = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_PUBLIC_EXP  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_PRIVATE_EXP = 2'd2;

   // status of the modular multiplier as seen by the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } mm_stat_type;

endpackage
`default_nettype wire

@@ rtl/core/rsame_cell.sv @@
`default_nettype none
// one bit of a shift row: parallel load or shift from the neighbor
module rsame_cell (
   input  wire logic clock,
   input  wire logic load,
   input  wire logic load_bit,
   input  wire logic shift,
   input  wire logic shift_in,
   output logic      bit_out
);
   logic bit_ff;
   logic bit_in;

   always_comb begin
      bit_in = bit_ff;
      if (load) begin
         bit_in = load_bit;
      end else if (shift) begin
         bit_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff <= bit_in;
   end

   assign bit_out = bit_ff;
endmodule
`default_nettype wire

@@ rtl/core/rsame_mulmod.sv @@
`default_nettype none
// (a * b) mod m by double-and-add, one bit of b per cycle, MSB first.
// b sits in a row of cells shifting toward the top. Needs a <= m, acc < m.
module rsame_mulmod #(
   parameter int WORD_BITS = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [WORD_BITS-1:0] a,
   input  wire logic [WORD_BITS-1:0] b,
   input  wire logic [WORD_BITS-1:0] m,
   output rsame_pkg::mm_stat_type    stat,
   output logic [WORD_BITS-1:0]      p
);
   import rsame_pkg::*;

   localparam int CNT_W = $clog2(WORD_BITS + 1);

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic [WORD_BITS-1:0] a_ff, m_ff;
   logic [WORD_BITS-1:0] b_bits;
   logic [WORD_BITS:0]   dbl, dbl_r, sum, sum_r;

   genvar gi;
   generate
      for (gi = 0; gi < WORD_BITS; gi++) begin : g_row
         if (gi == 0) begin : g_first
            rsame_cell u_cell (
               .clock   (clock),
               .load    (start),
               .load_bit(b[gi]),
               .shift   (run_ff),
               .shift_in(1'b0),
               .bit_out (b_bits[gi])
            );
         end else begin : g_rest
            rsame_cell u_cell (
               .clock   (clock),
               .load    (start),
               .load_bit(b[gi]),
               .shift   (run_ff),
               .shift_in(b_bits[gi-1]),
               .bit_out (b_bits[gi])
            );
         end
      end
   endgenerate

   // double, reduce, conditionally add a, reduce
   always_comb begin
      dbl   = {acc_ff, 1'b0};
      dbl_r = (dbl >= {1'b0, m_ff}) ? dbl - {1'b0, m_ff} : dbl;
      sum   = b_bits[WORD_BITS-1] ? dbl_r + {1'b0, a_ff} : dbl_r;
      sum_r = (sum >= {1'b0, m_ff}) ? sum - {1'b0, m_ff} : sum;
   end

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         acc_in = '0;
      end else if (run_ff) begin
         acc_in = sum_r[WORD_BITS-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(WORD_BITS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      if (start) begin
         a_ff <= a;
         m_ff <= m;
      end
   end

   assign stat.busy = run_ff;
   assign stat.done = done_ff;
   assign p         = acc_ff;
endmodule
`default_nettype wire

@@ rtl/core/rsa_modular_exponentiation.sv @@
`default_nettype none
// Channel  | Direction | Ports
// ---------+-----------+-------------------------------------------------
// req      | in        | req_valid, req_ready, req_operation, req_value
// rsp      | out       | rsp_valid, rsp_ready, rsp_result
// csr      | in        | csr_write_enable, csr_index, csr_write_data
//
// Cost: one modular multiply runs in the shared double-and-add unit
//   (one bit of the multiplier per cycle through its cell row).
// An item costs one reduction plus up to 2*WORD_BITS multiplies.
// Reset: synchronous, active high; modulus 1, exponents 0, both channels idle.
// Stalls: a finished result waits in the output register; the next request
//   is taken meanwhile and only its own completion waits on rsp_ready.
module rsa_modular_exponentiation #(
   parameter int WORD_BITS = rsame_pkg::WORD_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic                                 req_operation,
   input  wire logic [rsame_pkg::FIELD_BITS-1:0]     req_value,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [rsame_pkg::FIELD_BITS-1:0]          rsp_result,
   input  wire logic                                 csr_write_enable,
   input  wire logic [rsame_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [rsame_pkg::FIELD_BITS-1:0]     csr_write_data
);
   import rsame_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RED  = 3'd1;  // value mod m
   localparam logic [2:0] S_TEST = 3'd2;  // look at exponent LSB
   localparam logic [2:0] S_MUL  = 3'd3;  // acc * base
   localparam logic [2:0] S_SQR  = 3'd4;  // base * base
   localparam logic [2:0] S_OUT  = 3'd5;  // hand result to output reg

   // config registers
   logic [FIELD_BITS-1:0] modulus_ff, pub_exp_ff, priv_exp_ff;

   logic [2:0]           state_ff, state_in;
   logic                 mm_start_ff, mm_start_in;
   logic [WORD_BITS-1:0] m_ff, m_in;
   logic [WORD_BITS-1:0] v_ff, v_in;
   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic [WORD_BITS-1:0] base_ff, base_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [FIELD_BITS-1:0] rsp_result_ff, rsp_result_in;

   logic                 req_xfer;
   logic                 e_load, e_shift, e_zero;
   logic [WORD_BITS-1:0] e_bits, e_load_val;
   logic [63:0]          mod_x, exp_x, val_x, acc_x;
   logic [WORD_BITS-1:0] mod_w;
   logic [WORD_BITS-1:0] mm_a, mm_b, mm_p;
   mm_stat_type          mm_stat;

   // ---- configuration writes, unknown index ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff  <= FIELD_BITS'(1);
         pub_exp_ff  <= '0;
         priv_exp_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_MODULUS:     modulus_ff  <= csr_write_data;
            REG_PUBLIC_EXP:  pub_exp_ff  <= csr_write_data;
            REG_PRIVATE_EXP: priv_exp_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // ---- fit 32-bit fields to the datapath width
   assign mod_x = 64'(modulus_ff);
   assign exp_x = 64'((req_operation == OP_DECRYPT) ? priv_exp_ff : pub_exp_ff);
   assign val_x = 64'(req_value);
   assign acc_x = 64'(acc_ff);
   assign mod_w      = mod_x[WORD_BITS-1:0];
   assign e_load_val = exp_x[WORD_BITS-1:0];

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;

   // ---- exponent row: one cell per bit, shifts toward bit 0
   genvar gi;
   generate
      for (gi = 0; gi < WORD_BITS; gi++) begin : g_exp
         if (gi == WORD_BITS - 1) begin : g_top
            rsame_cell u_cell (
               .clock   (clock),
               .load    (e_load),
               .load_bit(e_load_val[gi]),
               .shift   (e_shift),
               .shift_in(1'b0),
               .bit_out (e_bits[gi])
            );
         end else begin : g_mid
            rsame_cell u_cell (
               .clock   (clock),
               .load    (e_load),
               .load_bit(e_load_val[gi]),
               .shift   (e_shift),
               .shift_in(e_bits[gi+1]),
               .bit_out (e_bits[gi])
            );
         end
      end
   endgenerate

   assign e_load = req_xfer;
   assign e_zero = (e_bits == '0);

   // ---- shared modular multiplier; operands picked by state
   always_comb begin
      mm_a = base_ff;
      mm_b = base_ff;
      case (state_ff)
         S_RED: begin
            mm_a = WORD_BITS'(1);
            mm_b = v_ff;
         end
         S_MUL: begin
            mm_a = acc_ff;
         end
         default: ;
      endcase
   end

   rsame_mulmod #(
      .WORD_BITS(WORD_BITS)
   ) u_mulmod (
      .clock(clock),
      .reset(reset),
      .start(mm_start_ff),
      .a    (mm_a),
      .b    (mm_b),
      .m    (m_ff),
      .stat (mm_stat),
      .p    (mm_p)
   );

   // ---- sequencer
   always_comb begin
      state_in      = state_ff;
      mm_start_in   = 1'b0;
      m_in          = m_ff;
      v_in          = v_ff;
      acc_in        = acc_ff;
      base_in       = base_ff;
      e_shift       = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_result_in = rsp_result_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               m_in        = (mod_w == '0) ? WORD_BITS'(1) : mod_w;
               v_in        = val_x[WORD_BITS-1:0];
               state_in    = S_RED;
               mm_start_in = 1'b1;
            end
         end
         S_RED: begin
            if (mm_stat.done) begin
               base_in  = mm_p;
               // acc = 1 even for m = 1; the first acc * base folds it to 0
               acc_in   = WORD_BITS'(1);
               state_in = S_TEST;
            end
         end
         S_TEST: begin
            if (e_zero) begin
               state_in = S_OUT;
            end else if (e_bits[0]) begin
               state_in    = S_MUL;
               mm_start_in = 1'b1;
            end else begin
               e_shift     = 1'b1;
               state_in    = S_SQR;
               mm_start_in = 1'b1;
            end
         end
         S_MUL: begin
            if (mm_stat.done) begin
               acc_in      = mm_p;
               e_shift     = 1'b1;
               state_in    = S_SQR;
               mm_start_in = 1'b1;
            end
         end
         S_SQR: begin
            if (mm_stat.done) begin
               base_in  = mm_p;
               state_in = S_TEST;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = acc_x[FIELD_BITS-1:0];
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mm_start_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mm_start_ff  <= mm_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      m_ff          <= m_in;
      v_ff          <= v_in;
      acc_ff        <= acc_in;
      base_ff       <= base_in;
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

`ifndef NO_ASSERTIONS
   // a new request never lands on a running multiply
   a_req_mm_idle: assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> !mm_stat.busy && !mm_start_ff)
      else $error("request taken while multiplier busy");

   // multiplier completions only while the sequencer waits for one
   a_done_owned: assert property (@(posedge clock) disable iff (reset)
      mm_stat.done |-> (state_ff == S_RED || state_ff == S_MUL || state_ff == S_SQR))
      else $error("multiplier done in unexpected state");

   // result is handed over only once the exponent is used up
   a_out_e_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |-> e_zero)
      else $error("output state with exponent bits left");
`endif
endmodule
`default_nettype wire

@@ tb/tb_rsa_modular_exponentiation.sv @@
`timescale 1ns / 100ps
module tb_rsa_modular_exponentiation;
   import rsame_pkg::*;

   // index with no register behind it; writes there must be dropped
   localparam logic [CSR_IDX_BITS-1:0] REG_UNUSED = 2'd3;

   typedef enum logic {ROW_CSR, ROW_ITEM} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [CSR_IDX_BITS-1:0] index;   // register, for csr rows
      logic operation;                  // for item rows
      logic [31:0] data;                // register data or item value
      bit fixed;                        // result typed in below
      logic [31:0] fixed_result;
   } stim_row_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic req_operation;
   logic [FIELD_BITS-1:0] req_value;
   logic rsp_valid;
   logic rsp_ready;
   logic [FIELD_BITS-1:0] rsp_result;
   logic csr_write_enable;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [FIELD_BITS-1:0] csr_write_data;

   // local copy of the key registers
   logic [31:0] key_modulus;
   logic [31:0] key_public;
   logic [31:0] key_private;

   logic [31:0] expected_results[$];
   int errors;
   int send_idle_pct;
   int recv_idle_pct;
   bit row_fixed;
   logic [31:0] row_fixed_result;

   rsa_modular_exponentiation dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operation(req_operation),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_result(rsp_result),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // exact modular product, full 64-bit intermediate
   function automatic logic [31:0] mul_mod(logic [31:0] a, logic [31:0] b, logic [31:0] m);
      logic [63:0] prod;
      prod = {32'd0, a} * {32'd0, b};
      return 32'(prod % {32'd0, m});
   endfunction

   // right-to-left square and multiply; modulus 0 acts as modulus 1
   function automatic logic [31:0] power_mod(logic [31:0] base, logic [31:0] ex,
                                             logic [31:0] m);
      logic [31:0] acc;
      logic [31:0] mm;
      logic [31:0] b;
      mm = (m == 32'd0) ? 32'd1 : m;
      acc = 32'd1;
      b = base % mm;
      for (int i = 0; i < 32; i++) begin
         if (ex == 32'd0) break;
         if (ex[0]) acc = mul_mod(acc % mm, b, mm);
         ex = ex >> 1;
         b = mul_mod(b, b, mm);
      end
      return acc;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // Scoreboard: predict on every request transfer, check on every response transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (row_fixed)
               expected_results.push_back(row_fixed_result);
            else
               expected_results.push_back(power_mod(req_value,
                  (req_operation == OP_DECRYPT) ? key_private : key_public, key_modulus));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0)
               report("unexpected result", rsp_result, 32'd0);
            else if (rsp_result !== expected_results[0]) begin
               report("result", rsp_result, expected_results[0]);
               void'(expected_results.pop_front());
            end else
               void'(expected_results.pop_front());
         end
      end
   end

   // Receiver stall, redrawn every cycle.
   always @(negedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic wait_drained();
      while (expected_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Register write; only called with the block drained.
   task automatic write_key(logic [CSR_IDX_BITS-1:0] idx, logic [31:0] data);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
      case (idx)
         REG_MODULUS:     key_modulus = data;
         REG_PUBLIC_EXP:  key_public = data;
         REG_PRIVATE_EXP: key_private = data;
         default: ;
      endcase
   endtask

   task automatic send(logic op, logic [31:0] value, bit fixed, logic [31:0] fixed_result);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_valid = 1'b1;
      req_operation = op;
      req_value = value;
      row_fixed = fixed;
      row_fixed_result = fixed_result;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
      req_valid = 1'b0;
      row_fixed = 1'b0;
   endtask

   function automatic logic [31:0] pick_exponent();
      case ($urandom_range(9))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom;
         default: return $urandom >> $urandom_range(31, 14);  // mostly short keys
      endcase
   endfunction

   function automatic logic [31:0] pick_modulus();
      case ($urandom_range(7))
         0: return 32'd1;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(2, 255);
         3: return 32'h8000_0000 | $urandom;
         default: return $urandom | 32'd1;
      endcase
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(7))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return key_modulus - 32'd1;
         3: return key_modulus;
         default: return $urandom;
      endcase
   endfunction

   stim_row_type directed_rows[] = '{
      // after reset: modulus 1, both exponents 0, so everything gives 1
      '{ROW_ITEM, REG_MODULUS, OP_ENCRYPT, 32'h0000_0000, 1'b1, 32'd1},
      '{ROW_ITEM, REG_MODULUS, OP_DECRYPT, 32'hFFFF_FFFF, 1'b1, 32'd1},
      // modulus one with a nonzero exponent gives 0, zero exponent still 1
      '{ROW_CSR, REG_PUBLIC_EXP, OP_ENCRYPT, 32'd5, 1'b0, 32'd0},
      '{ROW_ITEM, REG_MODULUS, OP_ENCRYPT, 32'd7, 1'b1, 32'd0},
      '{ROW_ITEM, REG_MODULUS, OP_DECRYPT, 32'd7, 1'b1, 32'd1},
      // largest modulus; private exponent 1 just reduces the value, public one is all ones
      '{ROW_CSR, REG_MODULUS, OP_ENCRYPT, 32'hFFFF_FFFF, 1'b0, 32'd0},
      '{ROW_CSR, REG_PRIVATE_EXP, OP_ENCRYPT, 32'd1, 1'b0, 32'd0},
      '{ROW_CSR, REG_PUBLIC_EXP, OP_ENCRYPT, 32'hFFFF_FFFF, 1'b0, 32'd0},
      '{ROW_ITEM, REG_MODULUS, OP_DECRYPT, 32'hFFFF_FFFF, 1'b1, 32'd0},
      '{ROW_ITEM, REG_MODULUS, OP_DECRYPT, 32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFE},
      '{ROW_ITEM, REG_MODULUS, OP_ENCRYPT, 32'd0, 1'b1, 32'd0},
      '{ROW_ITEM, REG_MODULUS, OP_ENCRYPT, 32'd1, 1'b1, 32'd1},
      '{ROW_ITEM, REG_MODULUS, OP_ENCRYPT, 32'hFFFF_FFFE, 1'b0, 32'd0},
      '{ROW_ITEM, REG_MODULUS, OP_ENCRYPT, 32'h1234_5678, 1'b0, 32'd0},
      // small textbook key pair, round trip
      '{ROW_CSR, REG_MODULUS, OP_ENCRYPT, 32'd3233, 1'b0, 32'd0},
      '{ROW_CSR, REG_PUBLIC_EXP, OP_ENCRYPT, 32'd17, 1'b0, 32'd0},
      '{ROW_CSR, REG_PRIVATE_EXP, OP_ENCRYPT, 32'd2753, 1'b0, 32'd0},
      '{ROW_ITEM, REG_MODULUS, OP_ENCRYPT, 32'd65, 1'b1, 32'd2790},
      '{ROW_ITEM, REG_MODULUS, OP_DECRYPT, 32'd2790, 1'b1, 32'd65},
      // write to an unmapped index is dropped
      '{ROW_CSR, REG_UNUSED, OP_ENCRYPT, 32'hFFFF_FFFF, 1'b0, 32'd0},
      '{ROW_ITEM, REG_MODULUS, OP_ENCRYPT, 32'd65, 1'b1, 32'd2790},
      // modulus zero behaves as modulus one
      '{ROW_CSR, REG_MODULUS, OP_ENCRYPT, 32'd0, 1'b0, 32'd0},
      '{ROW_ITEM, REG_MODULUS, OP_ENCRYPT, 32'hFFFF_FFFF, 1'b1, 32'd0}
   };

   initial begin
      errors = 0;
      send_idle_pct = 19;
      recv_idle_pct = 48;
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_ENCRYPT;
      req_value = '0;
      row_fixed = 1'b0;
      row_fixed_result = '0;
      csr_write_enable = 1'b0;
      csr_index = REG_MODULUS;
      csr_write_data = '0;
      key_modulus = 32'd1;
      key_public = 32'd0;
      key_private = 32'd0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            wait_drained();
            write_key(directed_rows[i].index, directed_rows[i].data);
         end else
            send(directed_rows[i].operation, directed_rows[i].data,
                 directed_rows[i].fixed, directed_rows[i].fixed_result);
      end

      // three idle patterns, each a few key settings with random traffic
      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 19 : (mode == 1) ? 48 : 0;
         recv_idle_pct = (mode == 0) ? 48 : (mode == 1) ? 19 : 0;
         for (int seg = 0; seg < 6; seg++) begin
            wait_drained();
            write_key(REG_MODULUS, pick_modulus());
            write_key(REG_PUBLIC_EXP, pick_exponent());
            write_key(REG_PRIVATE_EXP, pick_exponent());
            for (int n = 0; n < 16; n++)
               send($urandom_range(1), pick_value(), 1'b0, 32'd0);
         end
      end

      wait_drained();
      repeat (100) @(negedge clock);
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #50ms;
      $display("status: fail");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/rsame_pkg.sv
rtl/core/rsame_cell.sv
rtl/core/rsame_mulmod.sv
rtl/core/rsa_modular_exponentiation.sv
tb/tb_rsa_modular_exponentiation.sv
